@@ design/fucr_pkg.sv @@
// fucr_pkg: types, codes and command texts for the framed upgrade command receiver
// used by every module of the block; depends on nothing

package fucr_pkg;

   localparam int unsigned LEN_W   = 16;
   localparam int unsigned CMD_LEN = 13;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd1500;

   // verdict codes
   localparam logic [2:0] VERDICT_NONE      = 3'd0;
   localparam logic [2:0] VERDICT_START_OK  = 3'd1;
   localparam logic [2:0] VERDICT_START_BAD = 3'd2;
   localparam logic [2:0] VERDICT_DATA      = 3'd3;
   localparam logic [2:0] VERDICT_FINISH_OK = 3'd4;
   localparam logic [2:0] VERDICT_MISMATCH  = 3'd5;
   localparam logic [2:0] VERDICT_IGNORED   = 3'd6;
   localparam logic [2:0] VERDICT_OVERSIZE  = 3'd7;

   // upgrade phase codes
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_STARTED   = 2'd1;
   localparam logic [1:0] PHASE_RECEIVING = 2'd2;
   localparam logic [1:0] PHASE_FINISHED  = 2'd3;

   // number parser codes
   localparam logic [1:0] NUM_SKIP   = 2'd0;
   localparam logic [1:0] NUM_DIGITS = 2'd1;
   localparam logic [1:0] NUM_DONE   = 2'd2;

   localparam logic [7:0] START_TEXT [CMD_LEN] = '{
      8'h75, 8'h70, 8'h64, 8'h61, 8'h74, 8'h65, 8'h20,
      8'h73, 8'h74, 8'h61, 8'h72, 8'h74, 8'h3A };
   localparam logic [7:0] FINISH_TEXT [CMD_LEN] = '{
      8'h75, 8'h70, 8'h64, 8'h61, 8'h74, 8'h65, 8'h20,
      8'h66, 8'h69, 8'h6E, 8'h69, 8'h73, 8'h68 };

   typedef struct packed {
      logic       op;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [2:0]  verdict;
      logic [1:0]  upgrade_phase;
      logic [31:0] expected_size;
      logic [31:0] received_total;
   } rsp_type;

   typedef logic [LEN_W-1:0] csr_type;

   // what the frame parser hands to the upgrade controller for one item
   typedef struct packed {
      logic             reconnect;
      logic             oversize;
      logic             classify;
      logic             start_match;
      logic             finish_match;
      logic [LEN_W-1:0] length;
      logic [31:0]      size_value;
   } frame_evt_type;

endpackage

@@ design/fucr_chan_if.sv @@
// fucr_chan_if: valid/ready channel carrying one payload of a chosen type
// depends on nothing; payload types come from fucr_pkg at the instance

interface fucr_chan_if #(parameter type data_type = logic);

   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

@@ design/fucr_in_reg.sv @@
// fucr_in_reg: input register stage of the receiver
// depends on fucr_pkg and fucr_chan_if

module fucr_in_reg (
   input  logic             clock,
   input  logic             reset,
   fucr_chan_if.sink        req_if,
   input  logic             advance,
   output logic             item_valid,
   output fucr_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   fucr_pkg::req_type item_ff;

   // a held item leaving this cycle frees the slot for the next one
   assign req_if.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_if.ready) begin
         valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         item_ff <= req_if.data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/fucr_parser.sv @@
// fucr_parser: length-prefixed frame parser with command text matching and number parsing
// depends on fucr_pkg

module fucr_parser #(
   parameter int unsigned HEADER_BYTES = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  fucr_pkg::req_type                     item,
   input  logic [fucr_pkg::LEN_W-1:0]            max_payload,
   output fucr_pkg::frame_evt_type               frame_evt,
   output logic                                  payload_valid
);

   localparam int unsigned HC_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   logic                        frame_phase_ff, frame_phase_in;
   logic [HC_W-1:0]             hc_ff, hc_in;
   logic [fucr_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                        len_hi_ff, len_hi_in;
   logic [fucr_pkg::LEN_W-1:0]  pc_ff, pc_in;
   logic                        finish_ff, finish_in;
   logic                        start_ff, start_in;
   logic [1:0]                  nphase_ff, nphase_in;
   logic                        nneg_ff, nneg_in;
   logic [31:0]                 nval_ff, nval_in;

   logic [7:0]                  b;
   logic [fucr_pkg::LEN_W-1:0]  hdr_lo;
   logic                        hdr_hi;
   logic                        pos0, pos1, pos_hi, hdr_last;
   logic                        last_byte;
   logic                        m_start, m_finish;
   logic [1:0]                  s_phase;
   logic                        s_neg;
   logic [31:0]                 s_val;
   logic                        take_digit;

   assign b        = item.stream_byte;
   assign pos0     = (hc_ff == HC_W'(0));
   assign pos1     = (HEADER_BYTES > 1) && (hc_ff == HC_W'(1));
   assign pos_hi   = (HEADER_BYTES > 2) && (hc_ff >= HC_W'(2));
   assign hdr_last = (hc_ff == HC_W'(HEADER_BYTES - 1));
   assign last_byte = ({1'b0, pc_ff} + 17'd1) == {1'b0, len_ff};

   // little-endian length; anything above bit 15 only marks the frame as oversize
   always_comb begin
      hdr_lo = len_ff;
      if (pos0) begin
         hdr_lo[7:0] = b;
      end
      if (pos1) begin
         hdr_lo[15:8] = b;
      end
      hdr_hi = len_hi_ff || (pos_hi && (b != 8'd0));
   end

   // atoi-style number step, only on bytes after the command text
   always_comb begin
      s_phase    = nphase_ff;
      s_neg      = nneg_ff;
      s_val      = nval_ff;
      take_digit = 1'b0;
      if (pc_ff >= fucr_pkg::LEN_W'(fucr_pkg::CMD_LEN)) begin
         case (nphase_ff)
            fucr_pkg::NUM_SKIP: begin
               if (b inside {[8'd9:8'd13], 8'd32}) begin
                  s_phase = fucr_pkg::NUM_SKIP;
               end else if (b == 8'h2D || b == 8'h2B) begin
                  s_neg   = (b == 8'h2D);
                  s_phase = fucr_pkg::NUM_DIGITS;
               end else begin
                  s_phase    = fucr_pkg::NUM_DIGITS;
                  take_digit = 1'b1;
               end
            end
            fucr_pkg::NUM_DIGITS: begin
               take_digit = 1'b1;
            end
            default: begin
            end
         endcase
         if (take_digit) begin
            if (b inside {[8'h30:8'h39]}) begin
               s_val = (nval_ff << 3) + (nval_ff << 1) + {28'd0, b[3:0]};
            end else begin
               s_phase = fucr_pkg::NUM_DONE;
            end
         end
      end
   end

   // text matching: command bytes first, then the byte after must be zero for finish
   always_comb begin
      m_start  = start_ff;
      m_finish = finish_ff;
      if (pc_ff < fucr_pkg::LEN_W'(fucr_pkg::CMD_LEN)) begin
         m_start  = start_ff && (b == fucr_pkg::START_TEXT[pc_ff[3:0]]);
         m_finish = finish_ff && (b == fucr_pkg::FINISH_TEXT[pc_ff[3:0]]);
      end else if (pc_ff == fucr_pkg::LEN_W'(fucr_pkg::CMD_LEN) && b != 8'd0) begin
         m_finish = 1'b0;
      end
   end

   always_comb begin
      frame_phase_in = frame_phase_ff;
      hc_in          = hc_ff;
      len_in         = len_ff;
      len_hi_in      = len_hi_ff;
      pc_in          = pc_ff;
      finish_in      = finish_ff;
      start_in       = start_ff;
      nphase_in      = nphase_ff;
      nneg_in        = nneg_ff;
      nval_in        = nval_ff;
      frame_evt      = '0;
      payload_valid  = 1'b0;

      if (item.op || (!frame_phase_ff && hdr_last) || (frame_phase_ff && last_byte)) begin
         // header or frame ends here: parser state cleared, back to header phase unless a payload follows
         frame_phase_in = 1'b0;
         hc_in          = '0;
         len_in         = '0;
         len_hi_in      = 1'b0;
         pc_in          = '0;
         finish_in      = 1'b1;
         start_in       = 1'b1;
         nphase_in      = fucr_pkg::NUM_SKIP;
         nneg_in        = 1'b0;
         nval_in        = '0;
      end

      if (item.op) begin
         frame_evt.reconnect = 1'b1;
      end else if (!frame_phase_ff) begin
         if (hdr_last) begin
            if (hdr_hi || hdr_lo > max_payload) begin
               frame_evt.oversize = 1'b1;
            end else if (hdr_lo == '0) begin
               // empty frame is classified straight away
               frame_evt.classify     = 1'b1;
               frame_evt.start_match  = 1'b1;
               frame_evt.finish_match = 1'b1;
            end else begin
               frame_phase_in = 1'b1;
               len_in         = hdr_lo;
            end
         end else begin
            hc_in     = hc_ff + HC_W'(1);
            len_in    = hdr_lo;
            len_hi_in = hdr_hi;
         end
      end else begin
         payload_valid = 1'b1;
         if (last_byte) begin
            frame_evt.classify     = 1'b1;
            frame_evt.start_match  = m_start;
            frame_evt.finish_match = m_finish;
            frame_evt.length       = len_ff;
            frame_evt.size_value   = s_neg ? (32'd0 - s_val) : s_val;
         end else begin
            pc_in     = pc_ff + fucr_pkg::LEN_W'(1);
            start_in  = m_start;
            finish_in = m_finish;
            nphase_in = s_phase;
            nneg_in   = s_neg;
            nval_in   = s_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_phase_ff <= 1'b0;
         hc_ff          <= '0;
         len_ff         <= '0;
         len_hi_ff      <= 1'b0;
         pc_ff          <= '0;
         finish_ff      <= 1'b1;
         start_ff       <= 1'b1;
         nphase_ff      <= fucr_pkg::NUM_SKIP;
         nneg_ff        <= 1'b0;
         nval_ff        <= '0;
      end else if (enable) begin
         frame_phase_ff <= frame_phase_in;
         hc_ff          <= hc_in;
         len_ff         <= len_in;
         len_hi_ff      <= len_hi_in;
         pc_ff          <= pc_in;
         finish_ff      <= finish_in;
         start_ff       <= start_in;
         nphase_ff      <= nphase_in;
         nneg_ff        <= nneg_in;
         nval_ff        <= nval_in;
      end
   end

endmodule

@@ design/fucr_upgrade.sv @@
// fucr_upgrade: upgrade phase controller that classifies each finished frame
// depends on fucr_pkg

module fucr_upgrade (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  fucr_pkg::frame_evt_type frame_evt,
   output logic [2:0]              verdict,
   output logic [1:0]              upgrade_phase,
   output logic [31:0]             expected_size,
   output logic [31:0]             received_total
);

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] announced_ff, announced_in;
   logic [31:0] total_ff, total_in;

   always_comb begin
      phase_in     = phase_ff;
      announced_in = announced_ff;
      total_in     = total_ff;
      verdict      = fucr_pkg::VERDICT_NONE;
      if (frame_evt.reconnect) begin
         phase_in = fucr_pkg::PHASE_IDLE;
      end else if (frame_evt.oversize) begin
         verdict = fucr_pkg::VERDICT_OVERSIZE;
      end else if (frame_evt.classify) begin
         case (phase_ff)
            fucr_pkg::PHASE_IDLE: begin
               if (frame_evt.start_match &&
                   frame_evt.length >= fucr_pkg::LEN_W'(fucr_pkg::CMD_LEN)) begin
                  announced_in = frame_evt.size_value;
                  total_in     = '0;
                  phase_in     = fucr_pkg::PHASE_STARTED;
                  verdict      = fucr_pkg::VERDICT_START_OK;
               end else begin
                  verdict = fucr_pkg::VERDICT_START_BAD;
               end
            end
            fucr_pkg::PHASE_FINISHED: begin
               verdict = fucr_pkg::VERDICT_IGNORED;
            end
            default: begin
               if (frame_evt.finish_match) begin
                  if (total_ff == announced_ff) begin
                     phase_in = fucr_pkg::PHASE_FINISHED;
                     verdict  = fucr_pkg::VERDICT_FINISH_OK;
                  end else begin
                     phase_in = fucr_pkg::PHASE_IDLE;
                     verdict  = fucr_pkg::VERDICT_MISMATCH;
                  end
               end else begin
                  total_in = total_ff + {16'd0, frame_evt.length};
                  phase_in = fucr_pkg::PHASE_RECEIVING;
                  verdict  = fucr_pkg::VERDICT_DATA;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fucr_pkg::PHASE_IDLE;
         announced_ff <= '0;
         total_ff     <= '0;
      end else if (enable) begin
         phase_ff     <= phase_in;
         announced_ff <= announced_in;
         total_ff     <= total_in;
      end
   end

   // the result shows the state as it stands after this item
   assign upgrade_phase  = phase_in;
   assign expected_size  = announced_in;
   assign received_total = total_in;

endmodule

@@ design/framed_upgrade_command_receiver.sv @@
// framed_upgrade_command_receiver: top level with the result register and the csr
// depends on fucr_pkg, fucr_chan_if, fucr_in_reg, fucr_parser and fucr_upgrade
//
// usage
//   req_if (fucr_pkg::req_type): one stream byte or a reconnect per item
//   rsp_if (fucr_pkg::rsp_type): exactly one result item for every request item
//   csr_if (fucr_pkg::csr_type): max_payload writes, always ready, write only while idle
// a request item accepted into the input register moves on into the result register,
//   provided rsp_if is not stalled
// throughput: one item per cycle while rsp_if is not stalled; the input register and
//   the result register each hold one item, with the per-byte update logic between
//   them, so a stalled result still leaves the input register free to take one more item
// when rsp_if.ready is low the result holds and the input register fills, after which
//   req_if.ready drops until the result is taken
// reset: frame parser to header phase, upgrade phase idle, expected size and received
//   total zero, max_payload 1500, both stages empty

module framed_upgrade_command_receiver #(
   parameter int unsigned HEADER_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   fucr_chan_if.sink    req_if,
   fucr_chan_if.source  rsp_if,
   fucr_chan_if.sink    csr_if
);

   logic                       item_valid;
   fucr_pkg::req_type          item;
   logic                       advance;
   logic [fucr_pkg::LEN_W-1:0] max_payload_ff;
   fucr_pkg::frame_evt_type    frame_evt;
   logic                       payload_valid;
   logic [2:0]                 verdict;
   logic [1:0]                 upgrade_phase;
   logic [31:0]                expected_size;
   logic [31:0]                received_total;
   logic                       rsp_valid_ff, rsp_valid_in;
   fucr_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   assign advance = item_valid && (!rsp_valid_ff || rsp_if.ready);

   fucr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   fucr_parser #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .item          (item),
      .max_payload   (max_payload_ff),
      .frame_evt     (frame_evt),
      .payload_valid (payload_valid)
   );

   fucr_upgrade u_upgrade (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .frame_evt      (frame_evt),
      .verdict        (verdict),
      .upgrade_phase  (upgrade_phase),
      .expected_size  (expected_size),
      .received_total (received_total)
   );

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= fucr_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_if.valid) begin
         max_payload_ff <= csr_if.data;
      end
   end

   always_comb begin
      rsp_data_in.payload_valid  = payload_valid;
      rsp_data_in.payload_byte   = payload_valid ? item.stream_byte : 8'd0;
      rsp_data_in.verdict        = verdict;
      rsp_data_in.upgrade_phase  = upgrade_phase;
      rsp_data_in.expected_size  = expected_size;
      rsp_data_in.received_total = received_total;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // a reconnect always comes out as a plain idle result
   a_reconnect_result: assert property (@(posedge clock) disable iff (reset)
      advance && item.op |=> rsp_valid_ff && !rsp_data_ff.payload_valid &&
         rsp_data_ff.verdict == fucr_pkg::VERDICT_NONE &&
         rsp_data_ff.upgrade_phase == fucr_pkg::PHASE_IDLE)
      else $error("reconnect did not give an idle result");

   // oversize is reported on a header byte, never on a payload byte
   a_oversize_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict == fucr_pkg::VERDICT_OVERSIZE |->
         !rsp_data_ff.payload_valid)
      else $error("oversize verdict on a payload byte");

   // a good start leaves the block started with the count cleared
   a_start_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict == fucr_pkg::VERDICT_START_OK |->
         rsp_data_ff.upgrade_phase == fucr_pkg::PHASE_STARTED &&
         rsp_data_ff.received_total == 32'd0)
      else $error("start ok without a cleared count");

   // finish ok only when the count matched the announced size
   a_finish_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict == fucr_pkg::VERDICT_FINISH_OK |->
         rsp_data_ff.upgrade_phase == fucr_pkg::PHASE_FINISHED &&
         rsp_data_ff.received_total == rsp_data_ff.expected_size)
      else $error("finish ok with a size mismatch");

endmodule

@@ tb/sv/fucr_scoreboard_pkg.sv @@
// fucr_scoreboard_pkg: result predictor and scoreboard for the framed upgrade command receiver
// depends on fucr_pkg for the item types, verdict, phase and number parser codes

package fucr_scoreboard_pkg;
   import fucr_pkg::*;

   localparam int unsigned FRAME_HEADER_BYTES = 4;
   localparam int unsigned CMD_BYTES          = 13;
   localparam int unsigned PRINT_CAP          = 40;
   localparam string       START_PHRASE       = "update start:";
   localparam string       FINISH_CMD         = "update finish";

   class upgrade_scoreboard;
      // register and upgrade progress
      logic [15:0] max_payload;
      logic [1:0]  upgrade_phase;
      logic [31:0] announced_size;
      logic [31:0] data_total;
      // frame parser
      bit          in_payload;
      int unsigned header_count;
      logic [63:0] frame_len;
      int unsigned byte_count;
      bit          finish_seen;
      bit          start_seen;
      logic [1:0]  num_state;
      bit          num_negative;
      logic [31:0] num_value;

      rsp_type     pending_results[$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned items_noted;
      int unsigned verdict_seen [8];

      function new();
         max_payload    = 16'd1500;
         upgrade_phase  = PHASE_IDLE;
         announced_size = '0;
         data_total     = '0;
         mismatches     = 0;
         results_checked = 0;
         items_noted    = 0;
         foreach (verdict_seen[i]) verdict_seen[i] = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         in_payload   = 1'b0;
         header_count = 0;
         frame_len    = '0;
         byte_count   = 0;
         finish_seen  = 1'b1;
         start_seen   = 1'b1;
         num_state    = NUM_SKIP;
         num_negative = 1'b0;
         num_value    = '0;
      endfunction

      // atoi-style reading of the size after the start text
      function void number_step(logic [7:0] b);
         if (num_state == NUM_SKIP) begin
            if (b == " " || (b >= 8'h09 && b <= 8'h0D)) return;
            if (b == "-" || b == "+") begin
               num_negative = (b == "-");
               num_state    = NUM_DIGITS;
               return;
            end
            num_state = NUM_DIGITS;
         end
         if (num_state == NUM_DIGITS) begin
            if (b >= "0" && b <= "9")
               num_value = num_value * 32'd10 + 32'(b) - 32'h30;
            else
               num_state = NUM_DONE;
         end
      endfunction

      function logic [2:0] classify(logic [31:0] len);
         if (upgrade_phase == PHASE_IDLE) begin
            if (start_seen && len >= CMD_BYTES) begin
               announced_size = num_negative ? 32'd0 - num_value : num_value;
               data_total     = '0;
               upgrade_phase  = PHASE_STARTED;
               return VERDICT_START_OK;
            end
            return VERDICT_START_BAD;
         end
         if (upgrade_phase == PHASE_FINISHED) return VERDICT_IGNORED;
         if (finish_seen) begin
            if (data_total == announced_size) begin
               upgrade_phase = PHASE_FINISHED;
               return VERDICT_FINISH_OK;
            end
            upgrade_phase = PHASE_IDLE;
            return VERDICT_MISMATCH;
         end
         data_total    = data_total + len;
         upgrade_phase = PHASE_RECEIVING;
         return VERDICT_DATA;
      endfunction

      function rsp_type next_result(req_type item);
         rsp_type     r;
         logic [7:0]  b;
         logic [63:0] len;
         int unsigned p;
         r = '0;
         b = item.stream_byte;
         if (item.op) begin
            clear_frame();
            upgrade_phase = PHASE_IDLE;
         end else if (!in_payload) begin
            frame_len = frame_len | (64'(b) << (8 * header_count));
            header_count++;
            if (header_count >= FRAME_HEADER_BYTES) begin
               len = frame_len;
               clear_frame();
               if (len > 64'(max_payload))
                  r.verdict = VERDICT_OVERSIZE;
               else if (len == 0)
                  r.verdict = classify(32'd0);
               else begin
                  frame_len  = len;
                  in_payload = 1'b1;
               end
            end
         end else begin
            p               = byte_count;
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            if (p < CMD_BYTES) begin
               if (b != FINISH_CMD[p]) finish_seen = 1'b0;
               if (b != START_PHRASE[p]) start_seen = 1'b0;
            end else begin
               if (p == CMD_BYTES && b != 8'h00) finish_seen = 1'b0;
               number_step(b);
            end
            byte_count = p + 1;
            if (64'(byte_count) >= frame_len) begin
               r.verdict = classify(frame_len[31:0]);
               clear_frame();
            end
         end
         r.upgrade_phase  = upgrade_phase;
         r.expected_size  = announced_size;
         r.received_total = data_total;
         return r;
      endfunction

      function void note_request(req_type item);
         rsp_type r;
         r = next_result(item);
         pending_results.push_back(r);
         items_noted++;
         verdict_seen[r.verdict]++;
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction

      // printing stops after a while, counting does not
      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("[%0t] error: %s", $time, msg);
      endtask

      task compare(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %0h, predicted %0h",
                             results_checked, field, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %0d arrived with nothing predicted", results_checked));
            return;
         end
         want = pending_results.pop_front();
         compare("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
         compare("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
         compare("verdict", 32'(got.verdict), 32'(want.verdict));
         compare("upgrade_phase", 32'(got.upgrade_phase), 32'(want.upgrade_phase));
         compare("expected_size", got.expected_size, want.expected_size);
         compare("received_total", got.received_total, want.received_total);
         results_checked++;
      endtask
   endclass

endpackage

@@ tb/sv/testbench.sv @@
// testbench: framed byte streams, reconnects and max_payload writes for the upgrade receiver
// depends on fucr_pkg, fucr_chan_if, fucr_scoreboard_pkg and the block's rtl

module testbench;
   import fucr_pkg::*;
   import fucr_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned PHASE_ITEMS   = 60;
   localparam logic        OP_BYTE       = 1'b0;
   localparam logic        OP_RECONNECT  = 1'b1;
   localparam logic [7:0]  BLANKS [6]    = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   typedef enum int unsigned {
      SINK_OPEN, SINK_COIN, SINK_EVERY_FOURTH, SINK_MOSTLY
   } sink_pattern_type;
   typedef logic [7:0] octets_type [$];

   logic clock;
   logic reset;

   fucr_chan_if #(.data_type(req_type)) req_if ();
   fucr_chan_if #(.data_type(rsp_type)) rsp_if ();
   fucr_chan_if #(.data_type(csr_type)) csr_if ();

   framed_upgrade_command_receiver #(.HEADER_BYTES(FRAME_HEADER_BYTES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   upgrade_scoreboard sb;
   octets_type        frame_q;
   logic [15:0]       cur_max;
   int unsigned       burst_left;
   int unsigned       items_sent;
   int unsigned       cycle_count;
   int unsigned       holds_done;
   bit                hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
   end

   // result side: stall patterns of varying length, plus a long hold-off on request
   initial begin : result_sink
      sink_pattern_type pattern;
      int unsigned      run;
      int unsigned      tick;
      tick = 0;
      wait (!reset);
      forever begin
         pattern = sink_pattern_type'($urandom_range(0, 3));
         run     = $urandom_range(16, 96);
         repeat (run) begin
            @(negedge clock);
            if (hold_request) begin
               rsp_if.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_request = 1'b0;
               holds_done++;
            end
            tick++;
            case (pattern)
               SINK_OPEN:         rsp_if.ready <= 1'b1;
               SINK_COIN:         rsp_if.ready <= 1'($urandom_range(0, 1));
               SINK_EVERY_FOURTH: rsp_if.ready <= (tick % 4) != 0;
               default:           rsp_if.ready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(input logic op, input logic [7:0] b);
      req_type     item;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      item.op          = op;
      item.stream_byte = b;
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_payload(input logic [15:0] value);
      wait_for_results();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.max_payload = value;
      cur_max        = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_header(input logic [31:0] len);
      int unsigned i;
      for (i = 0; i < FRAME_HEADER_BYTES; i++) send_item(OP_BYTE, len[8*i +: 8]);
   endtask

   // an oversize frame goes out as its header alone, as the block skips it
   task automatic send_frame();
      int unsigned i;
      send_header(32'(frame_q.size()));
      if (frame_q.size() <= cur_max)
         for (i = 0; i < frame_q.size(); i++) send_item(OP_BYTE, frame_q[i]);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
   endtask

   // start command whose number reads back as size, in one of several spellings
   task automatic build_start(input logic [31:0] size);
      logic [63:0] spelled;
      logic [7:0]  tail;
      frame_q.delete();
      push_text(START_PHRASE);
      repeat ($urandom_range(0, 2)) frame_q.push_back(BLANKS[$urandom_range(0, 5)]);
      if (size == 0 && $urandom_range(0, 2) == 0) begin
         // no digits at all reads as zero
         if ($urandom_range(0, 1)) frame_q.push_back("-");
      end else begin
         case ($urandom_range(0, 3))
            0: push_text($sformatf("%0d", size));
            1: begin
               frame_q.push_back("+");
               push_text($sformatf("%0d", size));
            end
            2: begin
               frame_q.push_back("-");
               push_text($sformatf("%0d", 32'd0 - size));
            end
            default: begin
               // wraps modulo 2^32 back to size
               spelled = {32'($urandom_range(1, 4000)), size};
               push_text($sformatf("%0d", spelled));
            end
         endcase
      end
      case ($urandom_range(0, 3))
         0: ;
         1: frame_q.push_back(8'h00);
         2: begin
            tail = 8'($urandom());
            if (tail >= "0" && tail <= "9") tail = "x";
            frame_q.push_back(tail);
         end
         default: push_text(" blk");
      endcase
   endtask

   task automatic build_data(input int unsigned len);
      frame_q.delete();
      if (len > CMD_BYTES && $urandom_range(0, 5) == 0) begin
         // finish text followed by a nonzero byte still counts as data
         push_text(FINISH_CMD);
         frame_q.push_back(8'($urandom_range(1, 255)));
      end
      while (frame_q.size() < len) frame_q.push_back(8'($urandom()));
   endtask

   task automatic build_finish();
      int unsigned cut;
      int unsigned i;
      frame_q.delete();
      cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CMD_BYTES - 1) : CMD_BYTES;
      for (i = 0; i < cut; i++) frame_q.push_back(FINISH_CMD[i]);
      if (cut == CMD_BYTES && $urandom_range(0, 2) == 0) begin
         frame_q.push_back(8'h00);
         repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom()));
      end
   endtask

   // start, data frames, finish, then at times one more data frame and a reconnect
   task automatic run_session();
      int unsigned lens[$];
      int unsigned cap;
      int unsigned total;
      int unsigned i;
      logic [31:0] size;
      cap   = ($urandom_range(0, 9) == 0) ? 200 : 24;
      cap   = (cur_max < cap) ? cur_max : cap;
      total = 0;
      if (cap != 0)
         repeat ($urandom_range(0, 5)) begin
            lens.push_back($urandom_range(1, cap));
            total += lens[lens.size() - 1];
         end
      case ($urandom_range(0, 5))
         0:       size = total + $urandom_range(1, 9);
         1:       size = $urandom();
         default: size = total;
      endcase
      build_start(size);
      send_frame();
      for (i = 0; i < lens.size(); i++) begin
         build_data(lens[i]);
         send_frame();
      end
      build_finish();
      send_frame();
      if ($urandom_range(0, 2) == 0) begin
         build_data($urandom_range(0, cap));
         send_frame();
      end
      if ($urandom_range(0, 3) != 0) send_item(OP_RECONNECT, 8'($urandom()));
   endtask

   // broken sequences; anything that leaves the parser out of step ends in a reconnect
   task automatic run_noise();
      logic [31:0] len;
      int unsigned pos;
      case ($urandom_range(0, 4))
         0: begin
            repeat ($urandom_range(4, 24))
               send_item(($urandom_range(0, 15) == 0) ? OP_RECONNECT : OP_BYTE, 8'($urandom()));
            send_item(OP_RECONNECT, 8'($urandom()));
         end
         1: begin
            len = $urandom();
            if (len <= 32'(cur_max)) len = 32'(cur_max) + 32'd1 + 32'($urandom_range(0, 9));
            send_header(len);
         end
         2: begin
            if (cur_max >= 2) begin
               len = $urandom_range(2, (cur_max < 40) ? cur_max : 40);
               send_header(len);
               repeat ($urandom_range(0, len - 1)) send_item(OP_BYTE, 8'($urandom()));
            end else begin
               send_item(OP_BYTE, 8'($urandom()));
               send_item(OP_BYTE, 8'($urandom()));
            end
            send_item(OP_RECONNECT, 8'($urandom()));
         end
         3: begin
            build_start($urandom());
            pos = $urandom_range(0, CMD_BYTES - 1);
            frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
            send_frame();
         end
         default: send_header(32'd0);
      endcase
   endtask

   initial begin : stimulus
      logic [15:0] settings [7];
      int unsigned phase_start;
      int unsigned i;
      int unsigned big_len;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.data   = '0;
      sb            = new();
      cur_max       = 16'd1500;
      burst_left    = 0;
      items_sent    = 0;
      holds_done    = 0;
      hold_request  = 1'b0;
      settings      = '{16'd1500, 16'd13, 16'd0, 16'd14, 16'hFFFF, 16'd37, 16'd0};
      settings[6]   = 16'($urandom_range(13, 120));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening at the reset value of max_payload
      send_item(OP_RECONNECT, 8'hFF);
      send_header(32'hFFFF_FFFF);
      frame_q.delete();
      push_text(START_PHRASE);
      push_text("7");
      send_frame();
      // empty frame while started is a finish, and 7 bytes never came
      send_header(32'd0);

      for (i = 0; i < 7; i++) begin
         write_max_payload(settings[i]);
         // block fills up behind the stalled result while items keep coming
         hold_request = 1'b1;
         phase_start  = items_sent;
         if (cur_max <= 300) begin
            build_data(cur_max);
            send_frame();
         end
         send_header(32'(cur_max) + 32'd1);
         if (cur_max == 16'hFFFF) begin
            big_len = $urandom_range(256, 300);
            build_start(32'(big_len));
            send_frame();
            build_data(big_len);
            send_frame();
            build_finish();
            send_frame();
            send_item(OP_RECONNECT, 8'($urandom()));
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) run_session();
            else run_noise();
            if ($urandom_range(0, 5) == 0) wait_for_results();
         end
      end

      wait_for_results();
      $display("covered %0d items, %0d results, 7 max_payload values, %0d long stalls",
               items_sent, sb.results_checked, holds_done);
      $display("verdicts none to oversize: %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.verdict_seen[VERDICT_NONE], sb.verdict_seen[VERDICT_START_OK],
               sb.verdict_seen[VERDICT_START_BAD], sb.verdict_seen[VERDICT_DATA],
               sb.verdict_seen[VERDICT_FINISH_OK], sb.verdict_seen[VERDICT_MISMATCH],
               sb.verdict_seen[VERDICT_IGNORED], sb.verdict_seen[VERDICT_OVERSIZE]);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
